// File: design/sspg_pkg.sv
// Shared types, constants and lookup functions for the seven-segment demo
// pattern generator. No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package sspg_pkg;

    localparam int MESSAGE_LENGTH = 27;
    localparam int POS_W          = $clog2(MESSAGE_LENGTH - 6);
    localparam int IDX_W          = $clog2(MESSAGE_LENGTH + 1);
    localparam int TICK_W         = 32;
    localparam int PERIOD_W       = 16;
    localparam int STEP_W         = 9;
    localparam int SUB_W          = 4;
    localparam int WORD_W         = 64;
    localparam int DIGITS         = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [SUB_W-1:0]    SUB_LAST     = 4'd9;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [1:0] {
        MODE_FULL   = 2'd0,
        MODE_RAMP   = 2'd1,
        MODE_SCROLL = 2'd2,
        MODE_BLANK  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                 mode;
        logic                  chosen;
        logic [TICK_W-1:0]     tick;
        logic [SUB_W-1:0]      sub;
        logic [STEP_W-1:0]     steps;
        logic [WORD_W-1:0]     store;
        logic [POS_W-1:0]      pos;
        logic [TICK_W-1:0]     next_tick;
        logic                  half;
    } t_state;

    typedef struct packed {
        logic              emit;
        logic [WORD_W-1:0] segments;
        logic [WORD_W-1:0] levels;
        t_mode             mode;
    } t_result;

    localparam logic [7:0] TEXT_WHOLE [0:10] = '{
        8'he4, 8'hb6, 8'h9e, 8'hbc, 8'h10, 8'h8e, 8'h60, 8'hec, 8'hbc, 8'h9e, 8'hef
    };
    localparam logic [7:0] TEXT_HALF [0:11] = '{
        8'h40, 8'h4d, 8'h69, 8'h61, 8'h09, 8'h60, 8'h00, 8'h6c, 8'h6d, 8'h69, 8'h60, 8'h0c
    };

    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] f;
        unique case (d)
            4'd0:    f = 8'hfc;
            4'd1:    f = 8'h60;
            4'd2:    f = 8'hda;
            4'd3:    f = 8'hf2;
            4'd4:    f = 8'h66;
            4'd5:    f = 8'hb6;
            4'd6:    f = 8'hbe;
            4'd7:    f = 8'he4;
            4'd8:    f = 8'hfe;
            4'd9:    f = 8'hf6;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] rom_whole(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] j;
        j = i - IDX_W'(8);
        if (int'(i) >= 8 && int'(i) < 19 && int'(i) < MESSAGE_LENGTH) begin
            return TEXT_WHOLE[j[3:0]];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] rom_half(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] j;
        j = i - IDX_W'(8);
        if (int'(i) >= 8 && int'(i) < 20 && int'(i) <= MESSAGE_LENGTH) begin
            return TEXT_HALF[j[3:0]];
        end
        return 8'h00;
    endfunction

endpackage

`default_nettype wire

// File: design/sspg_step.sv
// Next-state and result logic for one word of the pattern generator.
// Depends on sspg_pkg for the state and result structs and the lookup tables.
`timescale 1ns / 1ps
`default_nettype none

module sspg_step (
    input  wire sspg_pkg::t_state              i_state,
    input  wire logic                          i_cmd,
    input  wire logic [1:0]                    i_sel,
    input  wire logic [sspg_pkg::PERIOD_W-1:0] i_period,
    output sspg_pkg::t_state                   o_state,
    output sspg_pkg::t_result                  o_result
);

    sspg_pkg::t_state  n;
    sspg_pkg::t_result res;
    sspg_pkg::t_mode   sel_mode;
    logic [7:0]        v;
    logic [1:0]        hund;
    logic [6:0]        rem;
    logic [13:0]       prod;
    logic [3:0]        tens;
    logic [6:0]        tens_x10;
    logic [3:0]        ones;
    logic [7:0]        d0;
    logic [7:0]        d1;
    logic [sspg_pkg::POS_W-1:0] p;
    logic [sspg_pkg::IDX_W-1:0] idx;

    assign sel_mode = sspg_pkg::t_mode'(i_sel);

    // decimal split of the ramp level
    always_comb begin
        v = i_state.steps[7:0];
        if (i_state.steps[8]) begin
            v = ~i_state.steps[7:0];
        end
        if (v >= 8'd200) begin
            hund = 2'd2;
            rem  = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            hund = 2'd1;
            rem  = 7'(v - 8'd100);
        end else begin
            hund = 2'd0;
            rem  = v[6:0];
        end
        prod     = 14'(rem) * 14'd103;
        tens     = prod[13:10];
        tens_x10 = 7'(tens) * 7'd10;
        ones     = 4'(rem - tens_x10);
        d0       = (hund == 2'd0) ? 8'h00 : sspg_pkg::seg_font({2'b00, hund});
        d1       = (tens == 4'd0 && hund == 2'd0) ? 8'h00 : sspg_pkg::seg_font(tens);
    end

    always_comb begin
        n            = i_state;
        res.emit     = 1'b0;
        res.levels   = '1;
        p            = i_state.pos;
        idx          = '0;
        if (i_cmd == sspg_pkg::CMD_SAMPLE) begin
            if (!(i_state.chosen && i_state.mode == sel_mode)) begin
                n.chosen = 1'b1;
                n.mode   = sel_mode;
                n.tick   = '0;
                n.sub    = '0;
                n.steps  = '0;
                unique case (sel_mode)
                    sspg_pkg::MODE_FULL: begin
                        n.store    = '1;
                        res.emit   = 1'b1;
                        res.levels = '1;
                    end
                    sspg_pkg::MODE_BLANK: begin
                        n.store    = '0;
                        res.emit   = 1'b1;
                        res.levels = '0;
                    end
                    sspg_pkg::MODE_SCROLL: begin
                        n.pos       = '0;
                        n.next_tick = sspg_pkg::TICK_W'(i_period);
                    end
                    sspg_pkg::MODE_RAMP: begin
                    end
                endcase
            end
        end else if (i_state.chosen) begin
            unique case (i_state.mode)
                sspg_pkg::MODE_RAMP: begin
                    if (i_state.sub == '0) begin
                        n.store    = {32'hffff_ffff, 8'h00, sspg_pkg::seg_font(ones), d1, d0};
                        res.levels = {v, v, v, v, 32'hffff_ffff};
                        res.emit   = 1'b1;
                    end
                end
                sspg_pkg::MODE_SCROLL: begin
                    if (i_state.tick >= i_state.next_tick) begin
                        n.next_tick = i_state.next_tick + sspg_pkg::TICK_W'(i_period);
                        if (!i_state.half) begin
                            for (int k = 0; k < sspg_pkg::DIGITS; k++) begin
                                idx = sspg_pkg::IDX_W'(p) + sspg_pkg::IDX_W'(k);
                                n.store[8*k +: 8] = sspg_pkg::rom_whole(idx);
                            end
                            n.half = 1'b1;
                        end else begin
                            p = i_state.pos + 1'b1;
                            for (int k = 0; k < sspg_pkg::DIGITS; k++) begin
                                idx = sspg_pkg::IDX_W'(p) + sspg_pkg::IDX_W'(k);
                                n.store[8*k +: 8] = sspg_pkg::rom_half(idx);
                            end
                            n.half = 1'b0;
                        end
                        if (int'(p) >= sspg_pkg::MESSAGE_LENGTH - 7) begin
                            p = '0;
                        end
                        n.pos = p;
                    end
                    res.levels = '1;
                    res.emit   = 1'b1;
                end
                default: begin
                end
            endcase
            // advance the tick count and its decade split
            n.tick = i_state.tick + 1'b1;
            if (i_state.tick == '1) begin
                n.sub   = '0;
                n.steps = '0;
            end else if (i_state.sub == sspg_pkg::SUB_LAST) begin
                n.sub   = '0;
                n.steps = i_state.steps + 1'b1;
            end else begin
                n.sub = i_state.sub + 1'b1;
            end
        end
        res.segments = n.store;
        res.mode     = n.mode;
    end

    assign o_state  = n;
    assign o_result = res;

endmodule

`default_nettype wire

// File: design/seven_segment_demo_pattern_generator_core.sv
// Top level of the seven-segment demo pattern generator: input register,
// state and result registers around sspg_step. Depends on sspg_pkg, sspg_step.
//
// channel  | direction | handshake                  | payload
// in       | in        | i_in_valid / o_in_ready    | i_cmd, i_switch_mode
// out      | out       | o_out_valid / i_out_ready  | o_digit_segments, o_digit_levels,
//          |           |                            | o_active_mode
// cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_scroll_period
//
// One word per cycle sustained while the output is not stalled; a word that emits is held
// in the input register, then one pass of sspg_step loads its result into the result register.
// Synchronous active-low reset clears mode, counters, segment store and scroll state;
// scroll period resets to 100.
// A stalled output holds its word; the input register keeps accepting until it must hold.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_demo_pattern_generator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_cmd,
    input  wire logic [1:0]                    i_switch_mode,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [63:0]                        o_digit_segments,
    output logic [63:0]                        o_digit_levels,
    output logic [1:0]                         o_active_mode,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sspg_pkg::PERIOD_W-1:0] i_cfg_scroll_period
);

    logic                          r_in_valid;
    logic                          r_cmd;
    logic [1:0]                    r_sel;
    logic [sspg_pkg::PERIOD_W-1:0] r_period;
    sspg_pkg::t_state              r_state;
    sspg_pkg::t_state              n_state;
    sspg_pkg::t_result             n_result;
    logic                          r_out_valid;
    logic [63:0]                   r_out_seg;
    logic [63:0]                   r_out_lvl;
    logic [1:0]                    r_out_mode;
    logic                          advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    sspg_step u_step (
        .i_state  (r_state),
        .i_cmd    (r_cmd),
        .i_sel    (r_sel),
        .i_period (r_period),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_period    <= sspg_pkg::PERIOD_RESET;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_scroll_period;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && n_result.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= i_cmd;
            r_sel <= i_switch_mode;
        end
        if (advance && n_result.emit) begin
            r_out_seg  <= n_result.segments;
            r_out_lvl  <= n_result.levels;
            r_out_mode <= n_result.mode;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_digit_segments = r_out_seg;
    assign o_digit_levels   = r_out_lvl;
    assign o_active_mode    = r_out_mode;

endmodule

`default_nettype wire

// File: design/sspg_checker.sv
// Port-level checks for the seven-segment demo pattern generator, bound to the top.
// Depends on sspg_pkg for the mode codes.
`timescale 1ns / 1ps
`default_nettype none

module sspg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_digit_segments,
    input wire logic [63:0] o_digit_levels,
    input wire logic [1:0]  o_active_mode
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_digit_segments)
            && $stable(o_digit_levels) && $stable(o_active_mode))
        else $error("stalled output word changed");

    a_blank_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_active_mode == sspg_pkg::MODE_BLANK
            |-> o_digit_segments == 64'd0 && o_digit_levels == 64'd0)
        else $error("blank mode word not dark");

    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_active_mode == sspg_pkg::MODE_FULL
            || o_active_mode == sspg_pkg::MODE_SCROLL) |-> o_digit_levels == '1)
        else $error("full or scroll word not at full level");

    a_ramp_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_active_mode == sspg_pkg::MODE_RAMP
            |-> o_digit_levels[31:0] == 32'hffff_ffff
                && o_digit_segments[63:32] == 32'hffff_ffff
                && o_digit_segments[31:24] == 8'h00)
        else $error("ramp word layout wrong");

endmodule

bind seven_segment_demo_pattern_generator_core sspg_checker u_sspg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_digit_segments (o_digit_segments),
    .o_digit_levels   (o_digit_levels),
    .o_active_mode    (o_active_mode)
);

`default_nettype wire

// File: verif/tb_seven_segment_demo_pattern_generator_core.sv
// Self-checking testbench for seven_segment_demo_pattern_generator_core: a directed
// table, then random mode/tick streams, checked against an in-bench display predictor.
// Depends on sspg_pkg and the design files of the block.
`timescale 1ns / 1ps

module tb_seven_segment_demo_pattern_generator_core;

    localparam int LIMIT_CYCLES    = 500000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int LONG_RAMP_TICKS = 1100;

    localparam logic [7:0] DIGIT_GLYPH [0:9] = '{
        8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he4, 8'hfe, 8'hf6
    };

    typedef struct packed {
        logic [sspg_pkg::WORD_W-1:0] segs;
        logic [sspg_pkg::WORD_W-1:0] levels;
        sspg_pkg::t_mode             mode;
    } t_update;

    typedef struct packed {
        logic       cmd;
        logic [1:0] sel;
        logic       typed;
        logic       typed_emit;
        t_update    upd;
    } t_row;

    localparam t_update NO_UPDATE = '{'0, '0, sspg_pkg::MODE_FULL};
    localparam t_update ALL_LIT   = '{'1, '1, sspg_pkg::MODE_FULL};
    localparam t_update ALL_DARK  = '{'0, '0, sspg_pkg::MODE_BLANK};
    localparam t_update RAMP_ZERO = '{64'hffffffff_00fc0000, 64'h00000000_ffffffff,
                                      sspg_pkg::MODE_RAMP};

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          in_valid   = 1'b0;
    logic                          cmd        = 1'b0;
    logic [1:0]                    sel        = 2'd0;
    logic                          rx_ready   = 1'b0;
    logic                          cfg_valid  = 1'b0;
    logic [sspg_pkg::PERIOD_W-1:0] cfg_period = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [63:0]         o_digit_segments;
    logic [63:0]         o_digit_levels;
    logic [1:0]          o_active_mode;
    logic                o_cfg_ready;

    // display predictor state
    sspg_pkg::t_mode               pred_mode;
    logic                          mode_set;
    logic [sspg_pkg::TICK_W-1:0]   ticks;
    logic [sspg_pkg::TICK_W-1:0]   next_frame;
    logic [sspg_pkg::WORD_W-1:0]   shown;
    int                            pos;
    logic                          half;
    logic [sspg_pkg::PERIOD_W-1:0] period;

    t_update pending_updates [$];
    int      fails     = 0;
    int      cycles    = 0;
    int      send_idle = 19;
    int      recv_idle = 82;

    t_row directed_rows [0:18] = '{
        '{sspg_pkg::CMD_TICK,   2'd3,                  1'b1, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_TICK,   2'd0,                  1'b1, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_FULL,   1'b1, 1'b1, ALL_LIT},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_FULL,   1'b1, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_TICK,   2'd2,                  1'b1, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_BLANK,  1'b1, 1'b1, ALL_DARK},
        '{sspg_pkg::CMD_TICK,   2'd1,                  1'b1, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_RAMP,   1'b1, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_TICK,   2'd0,                  1'b1, 1'b1, RAMP_ZERO},
        '{sspg_pkg::CMD_TICK,   2'd3,                  1'b1, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_SCROLL, 1'b1, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_TICK,   2'd0,                  1'b0, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_TICK,   2'd3,                  1'b0, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_BLANK,  1'b1, 1'b1, ALL_DARK},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_SCROLL, 1'b0, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_TICK,   2'd1,                  1'b0, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_FULL,   1'b1, 1'b1, ALL_LIT},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_RAMP,   1'b1, 1'b0, NO_UPDATE},
        '{sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_RAMP,   1'b1, 1'b0, NO_UPDATE}
    };

    seven_segment_demo_pattern_generator_core i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_cmd               (cmd),
        .i_switch_mode       (sel),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (rx_ready),
        .o_digit_segments    (o_digit_segments),
        .o_digit_levels      (o_digit_levels),
        .o_active_mode       (o_active_mode),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_scroll_period (cfg_period)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic void predict_display(input logic c, input logic [1:0] s,
                                            output logic emit, output t_update upd);
        logic [sspg_pkg::TICK_W-1:0] steps;
        logic [7:0]                  v;
        logic [7:0]                  d0;
        logic [7:0]                  d1;
        int                          k;
        int                          idx;
        emit = 1'b0;
        upd  = NO_UPDATE;
        if (c == sspg_pkg::CMD_SAMPLE) begin
            if (mode_set && pred_mode == sspg_pkg::t_mode'(s)) begin
                return;
            end
            mode_set  = 1'b1;
            pred_mode = sspg_pkg::t_mode'(s);
            ticks     = '0;
            case (pred_mode)
                sspg_pkg::MODE_FULL: begin
                    shown = '1;
                    emit  = 1'b1;
                    upd   = ALL_LIT;
                end
                sspg_pkg::MODE_BLANK: begin
                    shown = '0;
                    emit  = 1'b1;
                    upd   = ALL_DARK;
                end
                sspg_pkg::MODE_SCROLL: begin
                    pos        = 0;
                    next_frame = sspg_pkg::TICK_W'(period);
                end
                default: ;
            endcase
            return;
        end
        if (!mode_set) begin
            return;
        end
        if (pred_mode == sspg_pkg::MODE_RAMP && ticks % 10 == 0) begin
            steps = ticks / 10;
            v     = steps[8] ? 8'd255 - steps[7:0] : steps[7:0];
            d0    = (v / 100 == 0) ? 8'h00 : DIGIT_GLYPH[v / 100];
            d1    = (d0 == 8'h00 && (v / 10) % 10 == 0) ? 8'h00 : DIGIT_GLYPH[(v / 10) % 10];
            shown = {32'hffffffff, 8'h00, DIGIT_GLYPH[v % 10], d1, d0};
            emit  = 1'b1;
            upd   = '{shown, {{4{v}}, 32'hffffffff}, sspg_pkg::MODE_RAMP};
        end else if (pred_mode == sspg_pkg::MODE_SCROLL) begin
            if (ticks >= next_frame) begin
                next_frame += sspg_pkg::TICK_W'(period);
                if (half) begin
                    pos++;
                end
                for (k = 0; k < sspg_pkg::DIGITS; k++) begin
                    idx = pos + k;
                    if (half) begin
                        shown[8*k +: 8] = (idx >= 8 && idx < 20
                                           && idx <= sspg_pkg::MESSAGE_LENGTH)
                                          ? sspg_pkg::TEXT_HALF[idx - 8] : 8'h00;
                    end else begin
                        shown[8*k +: 8] = (idx >= 8 && idx < 19
                                           && idx < sspg_pkg::MESSAGE_LENGTH)
                                          ? sspg_pkg::TEXT_WHOLE[idx - 8] : 8'h00;
                    end
                end
                half = !half;
                if (pos >= sspg_pkg::MESSAGE_LENGTH - 7) begin
                    pos = 0;
                end
            end
            emit = 1'b1;
            upd  = '{shown, '1, sspg_pkg::MODE_SCROLL};
        end
        ticks++;
    endfunction

    task automatic send_word(input logic c, input logic [1:0] s, input logic typed = 1'b0,
                             input logic typed_emit = 1'b0, input t_update typed_upd = '0);
        logic    emit;
        t_update upd;
        in_valid <= 1'b1;
        cmd      <= c;
        sel      <= s;
        @(posedge clk);
        while (!o_in_ready) begin
            @(posedge clk);
        end
        predict_display(c, s, emit, upd);
        if (typed) begin
            emit = typed_emit;
            upd  = typed_upd;
        end
        if (emit) begin
            pending_updates.push_back(upd);
        end
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_updates.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_period(input logic [sspg_pkg::PERIOD_W-1:0] value);
        cfg_valid  <= 1'b1;
        cfg_period <= value;
        @(posedge clk);
        while (!o_cfg_ready) begin
            @(posedge clk);
        end
        period = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly a mode pick followed by a run of ticks, with some raw noise words
    task automatic run_stream(input int n_items);
        int              made;
        int              run_len;
        sspg_pkg::t_mode m;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                send_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                made++;
            end else begin
                case ($urandom_range(0, 9))
                    0:          m = sspg_pkg::MODE_FULL;
                    1:          m = sspg_pkg::MODE_BLANK;
                    2, 3, 4, 5: m = sspg_pkg::MODE_RAMP;
                    default:    m = sspg_pkg::MODE_SCROLL;
                endcase
                send_word(sspg_pkg::CMD_SAMPLE, m);
                made++;
                if (m == sspg_pkg::MODE_RAMP || m == sspg_pkg::MODE_SCROLL) begin
                    run_len = $urandom_range(1, 60);
                end else begin
                    run_len = $urandom_range(1, 3);
                end
                made += run_len;
                repeat (run_len) send_word(sspg_pkg::CMD_TICK, 2'($urandom_range(0, 3)));
            end
        end
    endtask

    always @(negedge clk) begin
        rx_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk) begin : check_updates
        t_update want;
        if (rst_n && o_out_valid && rx_ready) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected update segs %h levels %h mode %0d", $time,
                         o_digit_segments, o_digit_levels, o_active_mode);
                fails++;
            end else begin
                want = pending_updates.pop_front();
                if (o_digit_segments !== want.segs) begin
                    $display("%0t: segments expected %h actual %h", $time,
                             want.segs, o_digit_segments);
                    fails++;
                end
                if (o_digit_levels !== want.levels) begin
                    $display("%0t: levels expected %h actual %h", $time,
                             want.levels, o_digit_levels);
                    fails++;
                end
                if (o_active_mode !== want.mode) begin
                    $display("%0t: mode expected %0d actual %0d", $time,
                             want.mode, o_active_mode);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int i;
        mode_set   = 1'b0;
        pred_mode  = sspg_pkg::MODE_FULL;
        ticks      = '0;
        next_frame = '0;
        shown      = '0;
        pos        = 0;
        half       = 1'b0;
        period     = sspg_pkg::PERIOD_RESET;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < 19; i++) begin
            send_word(directed_rows[i].cmd, directed_rows[i].sel, directed_rows[i].typed,
                      directed_rows[i].typed_emit, directed_rows[i].upd);
        end
        settle();

        write_period(16'd0);
        run_stream(110);
        settle();
        write_period(16'd1);
        run_stream(110);
        settle();

        send_idle = 82;
        recv_idle = 19;
        write_period(sspg_pkg::PERIOD_W'($urandom_range(2, 9)));
        run_stream(110);
        settle();
        write_period(16'd1);
        run_stream(110);
        settle();

        // hold ramp mode until the level shows three digits
        send_idle = 0;
        recv_idle = 0;
        write_period(16'hffff);
        send_word(sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_BLANK);
        send_word(sspg_pkg::CMD_SAMPLE, sspg_pkg::MODE_RAMP);
        repeat (LONG_RAMP_TICKS) send_word(sspg_pkg::CMD_TICK, 2'($urandom_range(0, 3)));
        run_stream(70);
        settle();
        write_period(sspg_pkg::PERIOD_W'($urandom_range(1, 20)));
        run_stream(70);
        settle();

        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
design/sspg_pkg.sv
design/sspg_step.sv
design/seven_segment_demo_pattern_generator_core.sv
design/sspg_checker.sv
verif/tb_seven_segment_demo_pattern_generator_core.sv
